FILE: src/cda_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared constants, types and calendar tables for the date arithmetic block.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int DIV_W = 30;
    localparam int DN_W  = 23;

    localparam logic [DN_W-1:0] RESET_DN = 23'd2436700;
    localparam logic [24:0]     MIN_DN   = 25'd1721426;
    localparam logic [24:0]     MAX_DN   = 25'd5373484;

    localparam logic [14:0] YEAR_OFS  = 15'd4800;
    localparam logic [14:0] CENT_OFS  = 15'd4900;
    localparam logic [24:0] JD_OFS    = 25'd32075;
    localparam logic [23:0] L_OFS     = 24'd68569;

    localparam logic [DIV_W-1:0] DIV_CENT  = 30'd100;
    localparam logic [DIV_W-1:0] DIV_N     = 30'd146097;
    localparam logic [DIV_W-1:0] DIV_I     = 30'd1461001;
    localparam logic [DIV_W-1:0] DIV_J     = 30'd2447;
    localparam logic [DIV_W-1:0] DIV_K     = 30'd80;
    localparam logic [DIV_W-1:0] DIV_WEEK  = 30'd7;

    // Reciprocals of the divisors, scaled by two to the power of the divider width.
    localparam logic [DIV_W-1:0] RCP_CENT = DIV_W'((64'd1 << DIV_W) / 64'(DIV_CENT));
    localparam logic [DIV_W-1:0] RCP_N    = DIV_W'((64'd1 << DIV_W) / 64'(DIV_N));
    localparam logic [DIV_W-1:0] RCP_I    = DIV_W'((64'd1 << DIV_W) / 64'(DIV_I));
    localparam logic [DIV_W-1:0] RCP_J    = DIV_W'((64'd1 << DIV_W) / 64'(DIV_J));
    localparam logic [DIV_W-1:0] RCP_K    = DIV_W'((64'd1 << DIV_W) / 64'(DIV_K));
    localparam logic [DIV_W-1:0] RCP_WEEK = DIV_W'((64'd1 << DIV_W) / 64'(DIV_WEEK));

    localparam logic [3:0]  DEF_MONTH = 4'd9;
    localparam logic [5:0]  DEF_DAY   = 6'd23;
    localparam logic [13:0] DEF_YEAR  = 14'd2020;

    typedef enum logic [2:0] {
        OP_REF, OP_LD, OP_N, OP_I, OP_J, OP_K, OP_Y, OP_W
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
        logic out_load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_load;
    } status_t;

    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0:    v = 9'd305;
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            4'd13:   v = 9'd336;
            4'd14:   v = 9'd367;
            default: v = 9'd397;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/calendar_date_arithmetic.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic
// Each word runs seven divisions, eight for a load, on one shared constant
// divider; one word is in flight, so a new word is taken only once the last
// result has been loaded into the result register.
// A stalled result holds the controller before the next result is loaded.
// Reset sets the stored date to 1959-05-11 and empties the output register.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // month_in[3:0], day_in[9:4], year_in[23:10], offset[46:24],
    // ref_month[50:47], ref_day[55:51], ref_year[69:56], zero fill above.
    input  logic [71:0] s_tdata,
    // command[0].
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // month_out[3:0], day_out[8:4], year_out[22:9], day_of_year[31:23],
    // weekday[34:32], days_between[57:35], zero fill above.
    output logic [63:0] m_tdata,
    // range_error[0].
    output logic        m_tuser
);
    import cda_pkg::*;

    cmd_t    cmd;
    status_t status;

    cda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cda_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second word accepted while a word is in progress.");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:32] != 3'd7)
        else $error("Weekday out of range.");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd12))
        else $error("Month out of range.");

endmodule

FILE: src/cda_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Divides by a constant through a reciprocal multiplication and one
// correction step, registering the product, the estimate and the result in turn.
// ----------------------------------------------------------------------------
module cda_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cda_pkg::DIV_W-1:0] dividend,
    input  logic [cda_pkg::DIV_W-1:0] divisor,
    input  logic [cda_pkg::DIV_W-1:0] recip,
    output logic [cda_pkg::DIV_W-1:0] quotient,
    output logic [cda_pkg::DIV_W-1:0] remainder,
    output logic                      done
);
    import cda_pkg::*;

    logic [DIV_W-1:0]   x_reg, x_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_W-1:0]   rcp_reg, rcp_next;
    logic [2*DIV_W-1:0] prod_reg, prod_next;
    logic [DIV_W-1:0]   est_reg, est_next;
    logic [DIV_W-1:0]   rem0_reg, rem0_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [2:0]         stage_reg, stage_next;
    logic               done_reg, done_next;
    logic [DIV_W-1:0]   est;
    logic [DIV_W-1:0]   back;
    logic               over;

    // The estimate is never more than one below the true quotient.
    assign est  = prod_reg[2*DIV_W-1:DIV_W];
    assign back = est * dvs_reg;
    assign over = (rem0_reg >= dvs_reg);

    always_comb begin
        x_next     = x_reg;
        dvs_next   = dvs_reg;
        rcp_next   = rcp_reg;
        prod_next  = prod_reg;
        est_next   = est_reg;
        rem0_next  = rem0_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        if (start) begin
            x_next   = dividend;
            dvs_next = divisor;
            rcp_next = recip;
        end
        if (stage_reg[0]) begin
            prod_next = {{DIV_W{1'b0}}, x_reg} * {{DIV_W{1'b0}}, rcp_reg};
        end
        if (stage_reg[1]) begin
            est_next  = est;
            rem0_next = x_reg - back;
        end
        if (stage_reg[2]) begin
            quo_next = over ? est_reg + DIV_W'(1) : est_reg;
            rem_next = over ? rem0_reg - dvs_reg : rem0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
        x_reg    <= x_next;
        dvs_reg  <= dvs_next;
        rcp_reg  <= rcp_next;
        prod_reg <= prod_next;
        est_reg  <= est_next;
        rem0_reg <= rem0_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: src/cda_datapath.sv
// ----------------------------------------------------------------------------
// Date arithmetic datapath
// Holds the day number and steps the date conversions through a shared divider.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  cda_pkg::cmd_t    cmd,
    output cda_pkg::status_t status,
    input  logic [71:0]      in_data,
    input  logic             in_user,
    output logic [63:0]      out_data,
    output logic             out_user
);
    import cda_pkg::*;

    logic [3:0]  f_month, f_rm;
    logic [5:0]  f_day;
    logic [4:0]  f_rd;
    logic [13:0] f_year, f_ry;
    logic [22:0] f_off;
    logic        f_valid;
    logic [24:0] shift_sum;
    logic        shift_bad;

    logic        is_load_reg;
    logic [3:0]  lm_reg, rm_reg;
    logic [5:0]  ld_reg;
    logic [4:0]  rd_reg;
    logic [13:0] ly_reg, ry_reg;
    logic        err_reg;
    logic [DN_W-1:0] dn_reg, dn_next;

    logic [23:0] base_reg, ref_jd_reg;
    logic [23:0] l_reg;
    logic [7:0]  n_reg;
    logic [8:0]  i_reg;
    logic [4:0]  j_reg;
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [13:0] y_reg;
    logic [8:0]  doy_reg;
    logic [2:0]  wd_reg;
    logic [22:0] diff_reg;
    logic [63:0] out_data_reg;
    logic        out_user_reg;

    logic [3:0]  sel_m;
    logic [5:0]  sel_d;
    logic [14:0] sel_y;
    logic        sel_a;
    logic [14:0] yofs;
    logic [24:0] base_prod;
    logic [24:0] base_sum;

    logic [DIV_W-1:0] div_a, div_b, div_m, div_q, div_r;
    logic             div_done;

    logic [9:0]  corr;
    logic [24:0] n_prod;
    logic [19:0] i_prod;
    logic        l2;
    logic        leap;
    logic [24:0] diff_full;

    assign f_month = in_data[3:0];
    assign f_day   = in_data[9:4];
    assign f_year  = in_data[23:10];
    assign f_off   = in_data[46:24];
    assign f_rm    = in_data[50:47];
    assign f_rd    = in_data[55:51];
    assign f_ry    = in_data[69:56];

    assign f_valid = (f_month != 4'd0) && (f_month <= 4'd12) && (f_day != 6'd0)
                  && (f_day <= 6'd31) && (f_year != 14'd0) && (f_year <= 14'd9999);

    assign shift_sum = {2'b00, dn_reg} + {{2{f_off[22]}}, f_off};
    assign shift_bad = ($signed(shift_sum) < $signed(MIN_DN))
                    || ($signed(shift_sum) > $signed(MAX_DN));

    assign sel_m = (cmd.op == OP_REF) ? rm_reg : lm_reg;
    assign sel_d = (cmd.op == OP_REF) ? {1'b0, rd_reg} : ld_reg;
    assign sel_y = (cmd.op == OP_REF) ? {1'b0, ry_reg} : {1'b0, ly_reg};
    assign sel_a = (sel_m <= 4'd2);
    assign yofs  = sel_y + (sel_a ? 15'd0 : 15'd1) - 15'd1;

    assign base_prod = 25'd1461 * 25'(15'(yofs + YEAR_OFS));
    assign base_sum  = 25'(sel_d) + (base_prod >> 2) + 25'(month_term(sel_m)) - JD_OFS;

    assign corr   = (10'd3 * 10'(div_q[7:0])) >> 2;
    assign n_prod = (25'd146097 * 25'(div_q[7:0]) + 25'd3) >> 2;
    assign i_prod = (20'd1461 * 20'(div_q[8:0])) >> 2;
    assign l2     = (j_reg >= 5'd11);
    assign leap   = ((y_reg[1:0] == 2'b00) && (div_r != '0))
                 || ((div_r == '0) && (div_q[1:0] == 2'b00));
    assign diff_full = {1'b0, ref_jd_reg} - {2'b00, dn_reg};

    always_comb begin
        unique case (cmd.op)
            OP_REF, OP_LD: begin
                div_a = DIV_W'(15'(yofs + CENT_OFS));
                div_b = DIV_CENT;
                div_m = RCP_CENT;
            end
            OP_N: begin
                div_a = DIV_W'({1'b0, dn_reg} + L_OFS) << 2;
                div_b = DIV_N;
                div_m = RCP_N;
            end
            OP_I: begin
                div_a = DIV_W'((DIV_W'(l_reg) + DIV_W'(1)) * DIV_W'(4000));
                div_b = DIV_I;
                div_m = RCP_I;
            end
            OP_J: begin
                div_a = DIV_W'(l_reg) * DIV_W'(80);
                div_b = DIV_J;
                div_m = RCP_J;
            end
            OP_K: begin
                div_a = DIV_W'(j_reg) * DIV_W'(2447);
                div_b = DIV_K;
                div_m = RCP_K;
            end
            OP_Y: begin
                div_a = DIV_W'(y_reg);
                div_b = DIV_CENT;
                div_m = RCP_CENT;
            end
            default: begin
                div_a = DIV_W'(dn_reg);
                div_b = DIV_WEEK;
                div_m = RCP_WEEK;
            end
        endcase
    end

    cda_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.issue),
        .dividend  (div_a),
        .divisor   (div_b),
        .recip     (div_m),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    always_comb begin
        dn_next = dn_reg;
        if (cmd.accept && in_user && !shift_bad) begin
            dn_next = shift_sum[DN_W-1:0];
        end else if (cmd.finish && cmd.op == OP_LD) begin
            dn_next = DN_W'(base_reg - 24'(corr));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_reg <= RESET_DN;
        end else begin
            dn_reg <= dn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_load_reg <= !in_user;
            lm_reg      <= f_valid ? f_month : DEF_MONTH;
            ld_reg      <= f_valid ? f_day : DEF_DAY;
            ly_reg      <= f_valid ? f_year : DEF_YEAR;
            rm_reg      <= f_rm;
            rd_reg      <= f_rd;
            ry_reg      <= f_ry;
            err_reg     <= in_user && shift_bad;
        end
        if (cmd.issue && (cmd.op == OP_REF || cmd.op == OP_LD)) begin
            base_reg <= base_sum[23:0];
        end
        if (cmd.issue && cmd.op == OP_N) begin
            l_reg <= {1'b0, dn_reg} + L_OFS;
        end
        if (cmd.finish) begin
            unique case (cmd.op)
                OP_REF: ref_jd_reg <= base_reg - 24'(corr);
                OP_LD: begin
                end
                OP_N: begin
                    n_reg <= div_q[7:0];
                    l_reg <= l_reg - n_prod[23:0];
                end
                OP_I: begin
                    i_reg <= div_q[8:0];
                    l_reg <= l_reg - 24'(i_prod) + 24'd31;
                end
                OP_J: j_reg <= div_q[4:0];
                OP_K: begin
                    d_reg <= 5'(l_reg - 24'(div_q[9:0]));
                    m_reg <= 4'(j_reg + 5'd2 - (l2 ? 5'd12 : 5'd0));
                    y_reg <= 14'(14'd100 * 14'(n_reg - 8'd49)) + 14'(i_reg) + 14'(l2);
                end
                OP_Y: begin
                    doy_reg <= days_before(m_reg) + 9'(d_reg)
                             + 9'((m_reg > 4'd2) && leap);
                end
                default: begin
                    wd_reg <= div_r[2:0];
                    if ($signed(diff_full) > $signed(25'd4194303)) begin
                        diff_reg <= 23'h3FFFFF;
                    end else if ($signed(diff_full) < -$signed(25'd4194304)) begin
                        diff_reg <= 23'h400000;
                    end else begin
                        diff_reg <= diff_full[22:0];
                    end
                end
            endcase
        end
        if (cmd.out_load) begin
            out_data_reg <= {6'd0, diff_reg, wd_reg, doy_reg, y_reg, d_reg, m_reg};
            out_user_reg <= err_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.is_load  = is_load_reg;
    assign out_data        = out_data_reg;
    assign out_user        = out_user_reg;

endmodule

FILE: src/cda_ctrl.sv
// ----------------------------------------------------------------------------
// Date arithmetic controller
// Sequences the conversion steps and owns both stream handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  cda_pkg::status_t status,
    output cda_pkg::cmd_t    cmd
);
    import cda_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_REF;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cmd.accept   = 1'b0;
        cmd.issue    = 1'b0;
        cmd.finish   = 1'b0;
        cmd.out_load = 1'b0;
        cmd.op       = op_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    op_next    = OP_REF;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_ISSUE;
                    unique case (op_reg)
                        OP_REF:  op_next = status.is_load ? OP_LD : OP_N;
                        OP_LD:   op_next = OP_N;
                        OP_N:    op_next = OP_I;
                        OP_I:    op_next = OP_J;
                        OP_J:    op_next = OP_K;
                        OP_K:    op_next = OP_Y;
                        OP_Y:    op_next = OP_W;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            default: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
